### rtl/core/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache with pending requests.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int MAP_DEPTH_DEF  = 32;
    localparam int PEND_DEPTH_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int IFACE_W = 4;
    localparam int AGE_W   = 8;
    localparam int RETRY_W = 3;
    localparam int DATA_W  = 88;

    localparam logic [AGE_W-1:0]   MAX_AGE_RST        = 8'd15;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST    = 3'd5;
    localparam logic [AGE_W-1:0]   RETRY_INTERVAL_RST = 8'd1;
    localparam logic [AGE_W-1:0]   AGE_SAT            = 8'hFF;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_APPEND = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        K_MISS    = 3'd0,
        K_HIT     = 3'd1,
        K_QUEUED  = 3'd2,
        K_SEND    = 3'd3,
        K_RELEASE = 3'd4,
        K_UNREACH = 3'd5,
        K_FULL    = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        CFG_MAX_AGE        = 2'd0,
        CFG_RETRY_LIMIT    = 2'd1,
        CFG_RETRY_INTERVAL = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EXEC,
        ST_EMIT,
        ST_SCAN
    } st_t;

    typedef struct packed {
        logic wr;
        logic tick;
    } map_ctl_t;

    typedef struct packed {
        logic wr;
        logic clr;
        logic tick;
    } req_ctl_t;

endpackage

### rtl/core/arpc_map_cell.sv
// ----------------------------------------------------------------------------
// arpc_map_cell
// One entry of the address table with its own compare and aging logic.
// ----------------------------------------------------------------------------
module arpc_map_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  arpc_pkg::map_ctl_t                ctl,
    input  logic [arpc_pkg::IP_W-1:0]         key_ip,
    input  logic [arpc_pkg::MAC_W-1:0]        wr_mac,
    input  logic [arpc_pkg::AGE_W-1:0]        max_age,
    output logic                              valid,
    output logic                              hit,
    output logic [arpc_pkg::MAC_W-1:0]        mac
);
    import arpc_pkg::*;

    logic               valid_reg, valid_next;
    logic [IP_W-1:0]    ip_reg, ip_next;
    logic [MAC_W-1:0]   mac_reg, mac_next;
    logic [AGE_W-1:0]   age_reg, age_next;

    always_comb begin
        valid_next = valid_reg;
        ip_next    = ip_reg;
        mac_next   = mac_reg;
        age_next   = age_reg;
        if (ctl.wr) begin
            valid_next = 1'b1;
            ip_next    = key_ip;
            mac_next   = wr_mac;
            age_next   = '0;
        end else if (ctl.tick && valid_reg) begin
            if (age_reg >= max_age) begin
                valid_next = 1'b0;
            end else begin
                age_next = age_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ip_reg  <= ip_next;
        mac_reg <= mac_next;
        age_reg <= age_next;
    end

    assign valid = valid_reg;
    assign hit   = valid_reg && (ip_reg == key_ip);
    assign mac   = mac_reg;

endmodule

### rtl/core/arpc_req_cell.sv
// ----------------------------------------------------------------------------
// arpc_req_cell
// One pending address request with its own retry and timeout logic.
// ----------------------------------------------------------------------------
module arpc_req_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  arpc_pkg::req_ctl_t                ctl,
    input  logic [arpc_pkg::IP_W-1:0]         key_ip,
    input  logic [arpc_pkg::IFACE_W-1:0]      wr_iface,
    input  logic [arpc_pkg::RETRY_W-1:0]      retry_limit,
    input  logic [arpc_pkg::AGE_W-1:0]        retry_interval,
    output logic                              valid,
    output logic                              hit,
    output logic [arpc_pkg::IP_W-1:0]         ip,
    output logic [arpc_pkg::IFACE_W-1:0]      iface,
    output logic                              ev,
    output logic                              ev_unreach
);
    import arpc_pkg::*;

    logic                 valid_reg, valid_next;
    logic [IP_W-1:0]      ip_reg, ip_next;
    logic [IFACE_W-1:0]   iface_reg, iface_next;
    logic [AGE_W-1:0]     age_reg, age_next;
    logic [RETRY_W-1:0]   retries_reg, retries_next;
    logic [AGE_W-1:0]     age_inc;
    logic                 unreach;
    logic                 resend;

    assign age_inc = (age_reg != AGE_SAT) ? age_reg + 1'b1 : age_reg;
    assign unreach = retries_reg >= retry_limit;
    assign resend  = !unreach && (age_inc > retry_interval);

    always_comb begin
        valid_next   = valid_reg;
        ip_next      = ip_reg;
        iface_next   = iface_reg;
        age_next     = age_reg;
        retries_next = retries_reg;
        if (ctl.wr) begin
            valid_next   = 1'b1;
            ip_next      = key_ip;
            iface_next   = wr_iface;
            age_next     = '0;
            retries_next = '0;
        end else if (ctl.clr) begin
            valid_next = 1'b0;
        end else if (ctl.tick && valid_reg) begin
            if (unreach) begin
                valid_next = 1'b0;
            end else if (resend) begin
                retries_next = retries_reg + 1'b1;
                age_next     = '0;
            end else begin
                age_next = age_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ip_reg      <= ip_next;
        iface_reg   <= iface_next;
        age_reg     <= age_next;
        retries_reg <= retries_next;
    end

    assign valid      = valid_reg;
    assign hit        = valid_reg && (ip_reg == key_ip);
    assign ip         = ip_reg;
    assign iface      = iface_reg;
    assign ev         = valid_reg && (unreach || resend);
    assign ev_unreach = valid_reg && unreach;

endmodule

### rtl/core/arp_cache_with_pending_requests_unit.sv
// ----------------------------------------------------------------------------
// arp_cache_with_pending_requests_unit
// ARP cache with a table of pending address requests, built as rows of cells.
//
//   channel  dir  fields
//   s_       in   tuser: cmd; tdata: ip_addr, mac_addr, iface_id
//   m_       out  tuser: kind; tdata: out_ip, out_mac, out_iface; tlast: last
//   cfg_     in   cfg_index selects the register, cfg_data is written
//
// Lookup and append pass through the evaluate, execute and emit states, and
// emit waits for the output; insert and tick pass evaluate and execute and
// then enter the result scan, even when there is nothing to report.
// Every cell compares and ages in parallel.
// Reset clears all valid bits and loads the register defaults.
// A stalled result holds the scan; no request is taken until it finishes.
// ----------------------------------------------------------------------------
module arp_cache_with_pending_requests_unit #(
    parameter int MAP_DEPTH     = arpc_pkg::MAP_DEPTH_DEF,
    parameter int PENDING_DEPTH = arpc_pkg::PEND_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [arpc_pkg::DATA_W-1:0]   s_tdata,   // ip_addr, mac_addr, iface_id
    input  logic [1:0]                    s_tuser,   // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [arpc_pkg::DATA_W-1:0]   m_tdata,   // out_ip, out_mac, out_iface
    output logic [2:0]                    m_tuser,   // kind
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [arpc_pkg::AGE_W-1:0]    cfg_data
);
    import arpc_pkg::*;

    localparam int MIDX_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int RIDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    st_t                  state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [IP_W-1:0]      ip_reg;
    logic [MAC_W-1:0]     mac_reg;
    logic [IFACE_W-1:0]   iface_reg;
    logic [AGE_W-1:0]     max_age_reg;
    logic [RETRY_W-1:0]   retry_limit_reg;
    logic [AGE_W-1:0]     retry_int_reg;

    logic [MAP_DEPTH-1:0]     map_hit_vec_reg, map_free_vec_reg;
    logic [PENDING_DEPTH-1:0] req_hit_vec_reg, req_free_vec_reg;
    logic [PENDING_DEPTH-1:0] ev_mask_reg, ev_unr_reg;
    logic                     ev_rel_reg;
    logic [CNT_W-1:0]         res_cnt_reg;

    kind_t                res_kind_reg;
    logic [MAC_W-1:0]     res_mac_reg;
    logic [IFACE_W-1:0]   res_iface_reg;

    logic                 out_valid_reg;
    kind_t                out_kind_reg;
    logic [IP_W-1:0]      out_ip_reg;
    logic [MAC_W-1:0]     out_mac_reg;
    logic [IFACE_W-1:0]   out_iface_reg;
    logic                 out_last_reg;

    map_ctl_t             map_ctl [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] map_valid_w, map_hit_w;
    logic [MAC_W-1:0]     map_mac_w [MAP_DEPTH];

    req_ctl_t                 req_ctl [PENDING_DEPTH];
    logic [PENDING_DEPTH-1:0] req_valid_w, req_hit_w, req_ev_w, req_unr_w;
    logic [IP_W-1:0]          req_ip_w [PENDING_DEPTH];
    logic [IFACE_W-1:0]       req_iface_w [PENDING_DEPTH];

    logic [MIDX_W-1:0]        map_hit_idx, map_free_idx;
    logic [RIDX_W-1:0]        req_hit_idx, req_free_idx, ev_idx;
    logic [PENDING_DEPTH-1:0] ev_onehot;
    logic                     scan_last;
    logic                     out_free;
    logic                     accept;
    logic                     exec_en, emit_load, scan_load;

    genvar g;
    generate
        for (g = 0; g < MAP_DEPTH; g++) begin : g_map
            arpc_map_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (map_ctl[g]),
                .key_ip  (ip_reg),
                .wr_mac  (mac_reg),
                .max_age (max_age_reg),
                .valid   (map_valid_w[g]),
                .hit     (map_hit_w[g]),
                .mac     (map_mac_w[g])
            );
        end
        for (g = 0; g < PENDING_DEPTH; g++) begin : g_req
            arpc_req_cell u_cell (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .ctl            (req_ctl[g]),
                .key_ip         (ip_reg),
                .wr_iface       (iface_reg),
                .retry_limit    (retry_limit_reg),
                .retry_interval (retry_int_reg),
                .valid          (req_valid_w[g]),
                .hit            (req_hit_w[g]),
                .ip             (req_ip_w[g]),
                .iface          (req_iface_w[g]),
                .ev             (req_ev_w[g]),
                .ev_unreach     (req_unr_w[g])
            );
        end
    endgenerate

    always_comb begin
        map_hit_idx  = '0;
        map_free_idx = '0;
        for (int i = MAP_DEPTH - 1; i >= 0; i--) begin
            if (map_hit_vec_reg[i]) map_hit_idx = MIDX_W'(i);
            if (map_free_vec_reg[i]) map_free_idx = MIDX_W'(i);
        end
    end

    always_comb begin
        req_hit_idx  = '0;
        req_free_idx = '0;
        ev_idx       = '0;
        for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
            if (req_hit_vec_reg[i]) req_hit_idx = RIDX_W'(i);
            if (req_free_vec_reg[i]) req_free_idx = RIDX_W'(i);
            if (ev_mask_reg[i]) ev_idx = RIDX_W'(i);
        end
    end

    assign ev_onehot = ev_mask_reg & (~ev_mask_reg + 1'b1);
    assign scan_last = ((ev_mask_reg & ~ev_onehot) == '0)
                    || (res_cnt_reg == CNT_W'(MAX_RESULTS - 1));
    assign out_free  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_EVAL;
            ST_EVAL: state_next = ST_EXEC;
            ST_EXEC: begin
                if (cmd_reg == CMD_LOOKUP || cmd_reg == CMD_APPEND) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT: if (out_free) state_next = ST_IDLE;
            ST_SCAN: begin
                if (ev_mask_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (out_free && scan_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        exec_en   = 1'b0;
        emit_load = 1'b0;
        scan_load = 1'b0;
        for (int i = 0; i < MAP_DEPTH; i++) map_ctl[i] = '0;
        for (int i = 0; i < PENDING_DEPTH; i++) req_ctl[i] = '0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_EVAL: ;
            ST_EXEC: begin
                exec_en = 1'b1;
                case (cmd_reg)
                    CMD_INSERT: begin
                        map_ctl[map_free_idx].wr = 1'b1;
                        for (int i = 0; i < PENDING_DEPTH; i++) begin
                            req_ctl[i].clr = req_hit_vec_reg[i];
                        end
                    end
                    CMD_APPEND: begin
                        if (req_hit_vec_reg == '0 && req_free_vec_reg != '0) begin
                            req_ctl[req_free_idx].wr = 1'b1;
                        end
                    end
                    CMD_TICK: begin
                        for (int i = 0; i < MAP_DEPTH; i++) map_ctl[i].tick = 1'b1;
                        for (int i = 0; i < PENDING_DEPTH; i++) req_ctl[i].tick = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_EMIT: emit_load = out_free;
            ST_SCAN: scan_load = out_free && (ev_mask_reg != '0);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            max_age_reg     <= MAX_AGE_RST;
            retry_limit_reg <= RETRY_LIMIT_RST;
            retry_int_reg   <= RETRY_INTERVAL_RST;
            out_valid_reg   <= 1'b0;
            ev_mask_reg     <= '0;
            res_cnt_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MAX_AGE:        max_age_reg     <= cfg_data;
                    CFG_RETRY_LIMIT:    retry_limit_reg <= cfg_data[RETRY_W-1:0];
                    CFG_RETRY_INTERVAL: retry_int_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (emit_load || scan_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (exec_en) begin
                res_cnt_reg <= '0;
                case (cmd_reg)
                    CMD_INSERT: ev_mask_reg <= req_hit_vec_reg;
                    CMD_TICK:   ev_mask_reg <= req_ev_w;
                    default:    ev_mask_reg <= '0;
                endcase
            end else if (scan_load) begin
                res_cnt_reg <= res_cnt_reg + 1'b1;
                ev_mask_reg <= scan_last ? '0 : (ev_mask_reg & ~ev_onehot);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= cmd_t'(s_tuser);
            ip_reg    <= s_tdata[IP_W-1:0];
            mac_reg   <= s_tdata[IP_W +: MAC_W];
            iface_reg <= s_tdata[IP_W+MAC_W +: IFACE_W];
        end
        if (state_reg == ST_EVAL) begin
            map_hit_vec_reg  <= map_hit_w;
            map_free_vec_reg <= ~map_valid_w;
            req_hit_vec_reg  <= req_hit_w;
            req_free_vec_reg <= ~req_valid_w;
        end
        if (exec_en) begin
            ev_unr_reg <= req_unr_w;
            ev_rel_reg <= (cmd_reg == CMD_INSERT);
            res_mac_reg   <= '0;
            res_iface_reg <= '0;
            if (cmd_reg == CMD_LOOKUP) begin
                if (map_hit_vec_reg != '0) begin
                    res_kind_reg <= K_HIT;
                    res_mac_reg  <= map_mac_w[map_hit_idx];
                end else begin
                    res_kind_reg <= K_MISS;
                end
            end else if (req_hit_vec_reg != '0) begin
                res_kind_reg  <= K_QUEUED;
                res_iface_reg <= req_iface_w[req_hit_idx];
            end else begin
                res_kind_reg  <= (req_free_vec_reg != '0) ? K_SEND : K_FULL;
                res_iface_reg <= iface_reg;
            end
        end
        if (emit_load) begin
            out_kind_reg  <= res_kind_reg;
            out_ip_reg    <= ip_reg;
            out_mac_reg   <= res_mac_reg;
            out_iface_reg <= res_iface_reg;
            out_last_reg  <= 1'b1;
        end else if (scan_load) begin
            out_iface_reg <= req_iface_w[ev_idx];
            out_last_reg  <= scan_last;
            if (ev_rel_reg) begin
                out_kind_reg <= K_RELEASE;
                out_ip_reg   <= ip_reg;
                out_mac_reg  <= mac_reg;
            end else begin
                out_kind_reg <= ev_unr_reg[ev_idx] ? K_UNREACH : K_SEND;
                out_ip_reg   <= req_ip_w[ev_idx];
                out_mac_reg  <= '0;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_kind_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {{(DATA_W - IP_W - MAC_W - IFACE_W){1'b0}},
                        out_iface_reg, out_mac_reg, out_ip_reg};

    logic [MAP_DEPTH-1:0] map_wr_vec;
    always_comb begin
        for (int i = 0; i < MAP_DEPTH; i++) map_wr_vec[i] = map_ctl[i].wr;
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("request taken while busy");
    a_one_map_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(map_wr_vec))
        else $error("more than one table entry written");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count overflow");
    a_scan_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_load && scan_last) |=> (ev_mask_reg == '0))
        else $error("events left after final result");

endmodule

### test/tb_arp_cache_with_pending_requests_unit.sv
// ----------------------------------------------------------------------------
// tb_arp_cache_with_pending_requests_unit
// Checks the ARP cache against a behavioral copy of its tables: directed
// lookups, inserts, appends and ticks first, then random phases under several
// register settings, with random gaps and stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_arp_cache_with_pending_requests_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import arpc_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [3:0]  iface;
        logic        last;
    } arp_result_t;

    class arp_scoreboard;
        bit          map_valid [32];
        logic [31:0] map_ip    [32];
        logic [47:0] map_mac   [32];
        logic [7:0]  map_age   [32];
        bit          req_valid [16];
        logic [31:0] req_ip    [16];
        logic [3:0]  req_iface [16];
        logic [7:0]  req_age   [16];
        logic [2:0]  req_retries [16];
        logic [7:0]  max_age = 8'd15;
        logic [2:0]  retry_limit = 3'd5;
        logic [7:0]  retry_interval = 8'd1;
        arp_result_t pending_results [$];
        int          errors = 0;
        arp_result_t batch [$];

        function void add(kind_t k, logic [31:0] ip, logic [47:0] mac, logic [3:0] iface);
            arp_result_t r;
            if (batch.size() >= MAX_RESULTS) return;
            r.kind = k; r.ip = ip; r.mac = mac; r.iface = iface; r.last = 1'b0;
            batch.push_back(r);
        endfunction

        function void set_register(cfg_idx_t idx, logic [7:0] value);
            case (idx)
                CFG_MAX_AGE: max_age = value;
                CFG_RETRY_LIMIT: retry_limit = value[2:0];
                default: retry_interval = value;
            endcase
        endfunction

        function void note_request(cmd_t cmd, logic [31:0] ip, logic [47:0] mac,
                                   logic [3:0] iface);
            int i;
            int slot;
            batch.delete();
            slot = -1;
            case (cmd)
                CMD_LOOKUP: begin
                    for (i = 0; i < 32; i++)
                        if (slot < 0 && map_valid[i] && map_ip[i] == ip) slot = i;
                    if (slot >= 0) add(K_HIT, ip, map_mac[slot], 4'd0);
                    else add(K_MISS, ip, 48'd0, 4'd0);
                end
                CMD_INSERT: begin
                    for (i = 0; i < 32; i++)
                        if (slot < 0 && !map_valid[i]) slot = i;
                    if (slot < 0) slot = 0;
                    map_valid[slot] = 1; map_ip[slot] = ip;
                    map_mac[slot] = mac; map_age[slot] = 8'd0;
                    for (i = 0; i < 16; i++)
                        if (req_valid[i] && req_ip[i] == ip) begin
                            req_valid[i] = 0;
                            add(K_RELEASE, ip, mac, req_iface[i]);
                        end
                end
                CMD_APPEND: begin
                    for (i = 0; i < 16; i++)
                        if (slot < 0 && req_valid[i] && req_ip[i] == ip) slot = i;
                    if (slot >= 0) begin
                        add(K_QUEUED, ip, 48'd0, req_iface[slot]);
                    end else begin
                        for (i = 0; i < 16; i++)
                            if (slot < 0 && !req_valid[i]) slot = i;
                        if (slot >= 0) begin
                            req_valid[slot] = 1; req_ip[slot] = ip;
                            req_iface[slot] = iface; req_age[slot] = 8'd0;
                            req_retries[slot] = 3'd0;
                            add(K_SEND, ip, 48'd0, iface);
                        end else begin
                            add(K_FULL, ip, 48'd0, iface);
                        end
                    end
                end
                default: begin
                    for (i = 0; i < 32; i++)
                        if (map_valid[i]) begin
                            if (map_age[i] >= max_age) map_valid[i] = 0;
                            else map_age[i]++;
                        end
                    for (i = 0; i < 16; i++)
                        if (req_valid[i]) begin
                            if (req_age[i] != 8'hFF) req_age[i]++;
                            if (req_retries[i] >= retry_limit) begin
                                req_valid[i] = 0;
                                add(K_UNREACH, req_ip[i], 48'd0, req_iface[i]);
                            end else if (req_age[i] > retry_interval) begin
                                req_retries[i]++;
                                req_age[i] = 8'd0;
                                add(K_SEND, req_ip[i], 48'd0, req_iface[i]);
                            end
                        end
                end
            endcase
            if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
            foreach (batch[j]) pending_results.push_back(batch[j]);
        endfunction

        function void check_result(arp_result_t got);
            arp_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind) begin
                errors++;
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            end
            if (got.ip !== want.ip) begin
                errors++;
                $display("%0t: ip expected %h actual %h", $time, want.ip, got.ip);
            end
            if (got.mac !== want.mac) begin
                errors++;
                $display("%0t: mac expected %h actual %h", $time, want.mac, got.mac);
            end
            if (got.iface !== want.iface) begin
                errors++;
                $display("%0t: iface expected %h actual %h", $time, want.iface, got.iface);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic [2:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [7:0]        cfg_data;

    arp_scoreboard sb = new();
    bit            quiet = 0;
    logic [31:0]   ip_pool [24];

    arp_cache_with_pending_requests_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    function int draw_gap();
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic send_request(cmd_t cmd, logic [31:0] ip, logic [47:0] mac,
                                logic [3:0] iface);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'd0, iface, mac, ip};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, ip, mac, iface);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_request();
        int          pick;
        logic [31:0] ip;
        cmd_t        cmd;
        pick = $urandom_range(0, 99);
        if (pick < 30) cmd = CMD_LOOKUP;
        else if (pick < 50) cmd = CMD_INSERT;
        else if (pick < 80) cmd = CMD_APPEND;
        else cmd = CMD_TICK;
        ip = ($urandom_range(0, 3) != 0) ? ip_pool[$urandom_range(0, 23)] : $urandom;
        send_request(cmd, ip, 48'({$urandom, $urandom}), 4'($urandom_range(0, 15)));
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_LOOKUP;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MAX_AGE;
        cfg_data  <= '0;
        foreach (ip_pool[i]) ip_pool[i] = $urandom;
        ip_pool[0] = 32'h0;
        ip_pool[1] = 32'hFFFF_FFFF;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(CMD_LOOKUP, 32'h0, 48'h0, 4'h0);
        send_request(CMD_TICK, 32'h0, 48'h0, 4'h0);
        send_request(CMD_INSERT, 32'h0, 48'h0, 4'h0);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF);
        send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0, 4'h0);
        send_request(CMD_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF, 4'hF);
        send_request(CMD_APPEND, 32'hA5A5_5A5A, 48'h0, 4'hF);
        send_request(CMD_APPEND, 32'hA5A5_5A5A, 48'h0, 4'h3);
        send_request(CMD_APPEND, 32'h5A5A_A5A5, 48'h0, 4'h0);
        send_request(CMD_TICK, 32'h0, 48'h0, 4'h0);
        send_request(CMD_TICK, 32'h0, 48'h0, 4'h0);
        send_request(CMD_INSERT, 32'hA5A5_5A5A, 48'h1234_5678_9ABC, 4'h0);
        send_request(CMD_APPEND, 32'hFFFF_FFFF, 48'h0, 4'h7);
        repeat (8) send_request(CMD_TICK, 32'h0, 48'h0, 4'h0);
        send_request(CMD_LOOKUP, 32'hA5A5_5A5A, 48'h0, 4'h0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_register(CFG_MAX_AGE, 8'd255);
                    write_register(CFG_RETRY_LIMIT, 8'd7);
                    write_register(CFG_RETRY_INTERVAL, 8'd0);
                end
                1: begin
                    write_register(CFG_MAX_AGE, 8'd1);
                    write_register(CFG_RETRY_LIMIT, 8'd1);
                    write_register(CFG_RETRY_INTERVAL, 8'd255);
                end
                2: begin
                    write_register(CFG_MAX_AGE, 8'd0);
                    write_register(CFG_RETRY_LIMIT, 8'd0);
                    write_register(CFG_RETRY_INTERVAL, 8'd3);
                end
                default: begin
                    write_register(CFG_MAX_AGE, 8'd15);
                    write_register(CFG_RETRY_LIMIT, 8'd5);
                    write_register(CFG_RETRY_INTERVAL, 8'd1);
                end
            endcase
            for (int n = 0; n < 85; n++) begin
                if (n % 30 == 0) quiet = $urandom_range(0, 2) == 0;
                if (n == 40) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (sb.pending_results.size() != 0) @(posedge aclk);
                end
                random_request();
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        arp_result_t got;
        int stall;
        @(posedge aresetn);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            got.kind  = kind_t'(m_tuser);
            got.ip    = m_tdata[31:0];
            got.mac   = m_tdata[79:32];
            got.iface = m_tdata[83:80];
            got.last  = m_tlast;
            sb.check_result(got);
        end
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

### arp_cache_with_pending_requests_unit.f
rtl/core/arpc_pkg.sv
rtl/core/arpc_map_cell.sv
rtl/core/arpc_req_cell.sv
rtl/core/arp_cache_with_pending_requests_unit.sv
test/tb_arp_cache_with_pending_requests_unit.sv
